[design/fqsd_pkg.sv]
// Package for the FIFO queue with search/delete: codes, widths and FSM states.
`default_nettype none

package fqsd_pkg;

  // Default queue depth
  localparam int unsigned DEPTH_DEF = 16;

  // Fixed field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IN_W     = ((OP_W + 2 * DATA_W + 7) / 8) * 8;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_SEARCH = 3'd2,
    OP_DELETE = 3'd3,
    OP_MODIFY = 3'd4
  } op_e;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

endpackage : fqsd_pkg

`default_nettype wire

[design/fifo_queue_with_search_delete_unit.sv]
// Top level: bounded FIFO queue in one synchronous RAM with search, delete and modify.
//
//  channel  | dir | tdata fields (low bit up)                       | width
//  s_axis   | in  | operation[2:0], key[34:3], new_value[66:35], 0s | IN_W
//  m_axis   | out | status[1:0], occupancy[CW+1:2], 0s               | OUT_W
//
// Enqueue, dequeue and refused requests go from idle straight to the result state.
// Search and modify walk the RAM one entry per cycle through its single read port
// until a match or the end of the queue. Delete scans to the match, then copies the
// later entries down one place a cycle; on a miss it goes straight to the result state.
// Reset clears the control registers; the RAM and payload registers hold no reset value.
// A waiting result holds the next item in its result state until the earlier one is taken.
`default_nettype none

module fifo_queue_with_search_delete_unit #(
  parameter int unsigned DEPTH = fqsd_pkg::DEPTH_DEF,
  localparam int unsigned CW    = $clog2(DEPTH + 1),
  localparam int unsigned OUT_W = ((fqsd_pkg::STATUS_W + CW + 7) / 8) * 8
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // operation[2:0], key[34:3], new_value[66:35]
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire  [fqsd_pkg::IN_W-1:0]  s_axis_tdata,
  // status[1:0], occupancy[CW+1:2]
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  output logic [OUT_W-1:0]           m_axis_tdata
);

  import fqsd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  // Circular slot of a logical position
  function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, p};
    if (s >= (CW + 1)'(DEPTH)) s = s - (CW + 1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  // Control and request registers
  state_e                  state_q, state_d;
  logic [AW-1:0]           head_q, head_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           pos_q, pos_d;
  logic [CW-1:0]           wpos_q, wpos_d;
  logic                    dvld_q, dvld_d;
  logic [OP_W-1:0]         op_q, op_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic signed [DATA_W-1:0] nv_q, nv_d;
  status_e                 status_q, status_d;
  logic                    m_valid_q, m_valid_d;
  logic [OUT_W-1:0]        m_data_q, m_data_d;

  // RAM ports
  logic [DATA_W-1:0]       mem [DEPTH];
  logic [DATA_W-1:0]       rdata_q;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [DATA_W-1:0]       wdata;
  logic [AW-1:0]           raddr;
  logic                    rd_issue;

  // Input field split and shared conditions
  logic [OP_W-1:0]         in_op;
  logic [DATA_W-1:0]       in_key;
  logic [DATA_W-1:0]       in_nv;
  logic                    s_fire, out_free, q_empty, q_full;
  logic                    scan_hit, scan_end, shift_end;

  assign in_op     = s_axis_tdata[OP_W-1:0];
  assign in_key    = s_axis_tdata[OP_W+DATA_W-1:OP_W];
  assign in_nv     = s_axis_tdata[OP_W+2*DATA_W-1:OP_W+DATA_W];
  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign q_empty   = (count_q == '0);
  assign q_full    = (count_q == CW'(DEPTH));
  assign scan_hit  = dvld_q && (rdata_q == key_q);
  assign scan_end  = (pos_q >= count_q);
  assign shift_end = !dvld_q && (pos_q >= count_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if ((in_op == OP_SEARCH || in_op == OP_DELETE || in_op == OP_MODIFY) && !q_empty)
            state_d = S_SCAN;
          else
            state_d = S_RESP;
        end
      end
      S_SCAN: begin
        if (scan_hit) state_d = (op_q == OP_DELETE) ? S_SHIFT : S_RESP;
        else if (scan_end) state_d = S_RESP;
      end
      S_SHIFT: begin
        if (shift_end) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    m_axis_tvalid = m_valid_q;
    m_axis_tdata  = m_data_q;
  end

  // Datapath and RAM control
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    pos_d     = pos_q;
    wpos_d    = wpos_q;
    dvld_d    = dvld_q;
    op_d      = op_q;
    key_d     = key_q;
    nv_d      = nv_q;
    status_d  = status_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    we        = 1'b0;
    waddr     = slot_f(head_q, wpos_q);
    wdata     = rdata_q;
    raddr     = slot_f(head_q, pos_q);
    rd_issue  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          op_d     = in_op;
          key_d    = in_key;
          nv_d     = in_nv;
          pos_d    = '0;
          dvld_d   = 1'b0;
          status_d = ST_OK;
          case (in_op)
            OP_ENQ: begin
              if (q_full) begin
                status_d = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = slot_f(head_q, count_q);
                wdata   = in_key;
                count_d = count_q + 1'b1;
              end
            end
            OP_DEQ: begin
              if (q_empty) begin
                status_d = ST_EMPTY;
              end else begin
                head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
                count_d = count_q - 1'b1;
              end
            end
            OP_SEARCH, OP_DELETE, OP_MODIFY: begin
              if (q_empty) status_d = ST_EMPTY;
            end
            default: status_d = ST_MISSING;
          endcase
        end
      end

      // One read issued a cycle; compare the entry read the cycle before
      S_SCAN: begin
        rd_issue = !scan_hit && !scan_end;
        dvld_d   = rd_issue;
        if (rd_issue) begin
          pos_d  = pos_q + 1'b1;
          wpos_d = pos_q;
        end
        if (scan_hit) begin
          status_d = ST_OK;
          if (op_q == OP_MODIFY) begin
            we    = 1'b1;
            waddr = slot_f(head_q, wpos_q);
            wdata = nv_q;
          end else if (op_q == OP_DELETE) begin
            pos_d = wpos_q + 1'b1;
          end
        end else if (scan_end) begin
          status_d = ST_MISSING;
        end
      end

      // Copy each later entry down one place; read and write slots never coincide
      S_SHIFT: begin
        if (dvld_q) begin
          we     = 1'b1;
          waddr  = slot_f(head_q, wpos_q);
          wdata  = rdata_q;
          wpos_d = wpos_q + 1'b1;
        end
        rd_issue = (pos_q < count_q);
        dvld_d   = rd_issue;
        if (rd_issue) pos_d = pos_q + 1'b1;
        if (shift_end) count_d = count_q - 1'b1;
      end

      // Load the result register once it is free
      S_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_W'({count_q, status_q});
        end
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      pos_q     <= '0;
      wpos_q    <= '0;
      dvld_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      wpos_q    <= wpos_d;
      dvld_q    <= dvld_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    nv_q     <= nv_d;
    status_q <= status_d;
    m_data_q <= m_data_d;
  end

  // Entry RAM, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && in_op == OP_DEQ && !q_empty |=> count_q == $past(count_q) - 1'b1)
    else $error("dequeue did not drop one entry");

  a_full_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && in_op == OP_ENQ && q_full |=> count_q == CW'(DEPTH) && status_q == ST_FULL)
    else $error("full queue took an enqueue");

  a_shift_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT && we && rd_issue |-> waddr != raddr)
    else $error("shift read and write hit one slot");
`endif

endmodule : fifo_queue_with_search_delete_unit

`default_nettype wire
